// ===== sv/crlf_pkg.sv =====
// ----------------------------------------------------------------------------
// crlf_pkg
// Shared types, constants and helper functions of the CR LF frame receiver.
// ----------------------------------------------------------------------------
package crlf_pkg;

  // message buffer depth, one entry is kept for the terminator
  localparam int BUFFER_DEPTH = 64;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH);

  localparam int IDX_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int PHASE_W    = 3;
  localparam int OUT_DATA_W = 32;

  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TERM = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_C    = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_O    = 8'h4F;
  localparam logic [BYTE_W-1:0] CHAR_N    = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_G    = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_E    = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_T    = 8'h54;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [PHASE_W-1:0] PH_CODE_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CODE_CR1  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CODE_DATA = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CODE_CR2  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CODE_DONE = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_CR1  = 5'b00010,
    PH_DATA = 5'b00100,
    PH_CR2  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] count;
    logic             conn_ok;
    logic             get_ok;
    logic             ovf;
  } rx_state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               overflow;
    logic               is_get;
    logic               is_connect;
    logic [IDX_W-1:0]   frame_length;
    logic               frame_done;
    logic [BYTE_W-1:0]  write_byte;
    logic [IDX_W-1:0]   write_index;
    logic               write_valid;
  } rx_result_t;

  localparam int RES_W = $bits(rx_result_t);

  // low six bits of a CNT_W-wide count
  function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] c);
    logic [CNT_W+IDX_W-1:0] ext;
    ext = {{IDX_W{1'b0}}, c};
    return ext[IDX_W-1:0];
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
    logic [PHASE_W-1:0] code;
    case (p)
      PH_IDLE: code = PH_CODE_IDLE;
      PH_CR1:  code = PH_CODE_CR1;
      PH_DATA: code = PH_CODE_DATA;
      PH_CR2:  code = PH_CODE_CR2;
      PH_DONE: code = PH_CODE_DONE;
      default: code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [BYTE_W-1:0] conn_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      2'd0:    ch = CHAR_C;
      2'd1:    ch = CHAR_O;
      default: ch = CHAR_N;
    endcase
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] get_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      2'd0:    ch = CHAR_G;
      2'd1:    ch = CHAR_E;
      default: ch = CHAR_T;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/crlf_step.sv =====
// ----------------------------------------------------------------------------
// crlf_step
// Next receiver state and result for one input transaction.
// ----------------------------------------------------------------------------
module crlf_step
  import crlf_pkg::*;
(
  input  rx_state_t         cur,
  input  logic              func,
  input  logic [BYTE_W-1:0] rx_byte,
  output rx_state_t         nxt,
  output rx_result_t        res
);

  logic             is_cr;
  logic             is_lf;
  logic             has_room;
  logic             wv;
  logic [CNT_W-1:0] widx;
  logic [BYTE_W-1:0] wbyte;
  logic             done;

  assign is_cr    = (rx_byte == CHAR_CR);
  assign is_lf    = (rx_byte == CHAR_LF);
  assign has_room = (cur.count < CNT_W'(BUFFER_DEPTH - 1));

  always_comb begin
    nxt   = cur;
    wv    = 1'b0;
    widx  = '0;
    wbyte = '0;
    if (func == FUNC_RELEASE) begin
      if (cur.phase == PH_DONE) begin
        nxt.phase = PH_IDLE;
      end
    end else begin
      case (cur.phase)
        PH_IDLE: begin
          if (is_cr) begin
            nxt.phase = PH_CR1;
          end
        end
        PH_CR1: begin
          if (is_lf) begin
            nxt.phase   = PH_DATA;
            nxt.count   = '0;
            nxt.conn_ok = 1'b1;
            nxt.get_ok  = 1'b1;
            nxt.ovf     = 1'b0;
          end
        end
        PH_DATA: begin
          if (is_cr) begin
            nxt.phase = PH_CR2;
          end else if (has_room) begin
            wv        = 1'b1;
            widx      = cur.count;
            wbyte     = rx_byte;
            nxt.count = cur.count + CNT_W'(1);
            // prefix match only over the first few payload bytes
            if (cur.count < CNT_W'(4) && rx_byte != conn_char(cur.count[1:0])) begin
              nxt.conn_ok = 1'b0;
            end
            if (cur.count < CNT_W'(3) && rx_byte != get_char(cur.count[1:0])) begin
              nxt.get_ok = 1'b0;
            end
          end else begin
            nxt.ovf = 1'b1;
          end
        end
        PH_CR2: begin
          if (is_lf) begin
            nxt.phase = PH_DONE;
            wv        = 1'b1;
            widx      = cur.count;
            wbyte     = CHAR_TERM;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign done = (nxt.phase == PH_DONE);

  always_comb begin
    res.write_valid  = wv;
    res.write_index  = to_idx(widx);
    res.write_byte   = wbyte;
    res.frame_done   = done;
    res.frame_length = to_idx(nxt.count);
    res.is_connect   = done && nxt.conn_ok && (nxt.count >= CNT_W'(4));
    res.is_get       = done && nxt.get_ok && (nxt.count >= CNT_W'(3));
    res.overflow     = nxt.ovf;
    res.phase        = phase_code(nxt.phase);
  end

endmodule

// ===== sv/crlf_out_skid.sv =====
// ----------------------------------------------------------------------------
// crlf_out_skid
// Output register with a skid stage so input flow survives output stalls.
// ----------------------------------------------------------------------------
module crlf_out_skid
  import crlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rx_result_t push_data,
  output logic       can_push,
  output logic       out_valid,
  input  logic       out_ready,
  output rx_result_t out_data
);

  logic       main_vld_r;
  logic       skid_vld_r;
  rx_result_t main_data_r;
  rx_result_t skid_data_r;
  logic       main_free;

  assign main_free = !main_vld_r || out_ready;
  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_free) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_vld_r ? skid_data_r : push_data;
    end
    if (!main_free && push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// ===== sv/crlf_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crlf_frame_receiver
// Finds CR LF payload CR LF frames in a received byte stream.
// ----------------------------------------------------------------------------
// One input transaction gives exactly one result transaction. A new byte or
// release can be taken every clock cycle while in_tready is high; the result
// is held in an output register backed by a one-entry skid stage, so in_tready
// only drops once two results are waiting. Payload bytes come out as buffer
// writes at their index; the closing CR LF writes the '#' terminator and holds
// the frame (frame_done) until a release transaction (in_tuser = 1). Up to
// BUFFER_DEPTH-1 payload bytes are stored, later ones set overflow.
module crlf_frame_receiver
  import crlf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] write_valid, [6:1] write_index, [14:7] write_byte, [15] frame_done,
  // [21:16] frame_length, [22] is_connect, [23] is_get, [24] overflow,
  // [27:25] phase, [31:28] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  rx_state_t  state_r;
  rx_state_t  state_nxt;
  rx_result_t step_res;
  rx_result_t buf_res;
  logic       in_fire;

  assign in_fire = in_tvalid && in_tready;

  crlf_step u_step (
    .cur     (state_r),
    .func    (in_tuser),
    .rx_byte (in_tdata),
    .nxt     (state_nxt),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= PH_IDLE;
      state_r.count   <= '0;
      state_r.conn_ok <= 1'b1;
      state_r.get_ok  <= 1'b1;
      state_r.ovf     <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  crlf_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (step_res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (buf_res)
  );

  assign out_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, buf_res};

endmodule
